// ===== src/assert_macros.svh =====
// Assertion macros shared by the intcode processor modules.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/icp_pkg.sv =====
// Shared types, constants and decode functions for the intcode processor.
// No dependencies; used by icp_ctrl, icp_dp and intcode_processor_step.
package icp_pkg;

    localparam int MEM_WORDS_DEF   = 2048;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_W          = 64;
    localparam int LD_ADDR_W       = 11;

    // Kind of input word.
    typedef enum logic [1:0] {
        OPER_LOAD = 2'd0,
        OPER_PUSH = 2'd1,
        OPER_EXEC = 2'd2,
        OPER_NONE = 2'd3
    } t_oper;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_OUTPUT     = 4'd1,
        ST_NO_INPUT   = 4'd2,
        ST_HALT       = 4'd3,
        ST_END        = 4'd4,
        ST_BAD_OPCODE = 4'd5,
        ST_BAD_MODE   = 4'd6,
        ST_QUEUE_FULL = 4'd7,
        ST_ADDR_ERR   = 4'd8
    } t_status;

    // Decoded instruction class.
    typedef enum logic [3:0] {
        OPC_ADD, OPC_MUL, OPC_IN, OPC_OUT, OPC_JT, OPC_JF,
        OPC_LT, OPC_EQ, OPC_RB, OPC_HALT, OPC_BAD
    } t_opc;

    // Memory port address selection.
    typedef enum logic [2:0] {
        MA_CLR, MA_LOAD, MA_IP, MA_SLOT, MA_AD0, MA_AD1, MA_DEST
    } t_maddr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clr;
        logic    latch;
        logic    load_wr;
        logic    push;
        logic    word_load;
        logic    bcd_step;
        logic    op_store_imm;
        logic    op_store_mem;
        logic [1:0] k;
        logic    cap_x;
        logic    cap_y;
        logic    mul_step;
        logic [1:0] step;
        logic    exec;
        logic    res_load;
        t_status res_status;
        t_maddr  maddr;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  clr_done;
        t_oper oper;
        logic  ld_oob;
        logic  q_full;
        logic  q_empty;
        logic  ip_oob;
        logic  rd_neg;
        t_opc  opc;
        logic  mode_bad;
        logic  mode_imm;
        logic  slot_oob;
        logic  a_oob;
    } t_dp_stat;

    // Opcode from the tens and units digits.
    function automatic t_opc f_decode(input logic [3:0] d1, input logic [3:0] d0);
        t_opc r;
        r = OPC_BAD;
        if (d1 == 4'd0) begin
            case (d0)
                4'd1: r = OPC_ADD;
                4'd2: r = OPC_MUL;
                4'd3: r = OPC_IN;
                4'd4: r = OPC_OUT;
                4'd5: r = OPC_JT;
                4'd6: r = OPC_JF;
                4'd7: r = OPC_LT;
                4'd8: r = OPC_EQ;
                4'd9: r = OPC_RB;
                default: r = OPC_BAD;
            endcase
        end else if (d1 == 4'd9 && d0 == 4'd9) begin
            r = OPC_HALT;
        end
        return r;
    endfunction

    // Number of operands of an instruction.
    function automatic logic [1:0] f_nops(input t_opc opc);
        logic [1:0] n;
        case (opc)
            OPC_ADD, OPC_MUL, OPC_LT, OPC_EQ: n = 2'd3;
            OPC_JT, OPC_JF:                   n = 2'd2;
            OPC_IN, OPC_OUT, OPC_RB:          n = 2'd1;
            default:                          n = 2'd0;
        endcase
        return n;
    endfunction

    // True when the last operand is a destination.
    function automatic logic f_writes(input t_opc opc);
        logic w;
        case (opc)
            OPC_ADD, OPC_MUL, OPC_LT, OPC_EQ, OPC_IN: w = 1'b1;
            default:                                  w = 1'b0;
        endcase
        return w;
    endfunction

endpackage

// ===== src/icp_dp.sv =====
// Datapath of the intcode processor: data memory, input queue, registers,
// decimal decoder, operand resolution, multiplier and result register.
// Depends on icp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module icp_dp #(
    parameter int MEM_WORDS   = icp_pkg::MEM_WORDS_DEF,
    parameter int QUEUE_DEPTH = icp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  icp_pkg::t_dp_cmd               i_cmd,
    output icp_pkg::t_dp_stat              o_stat,
    input  logic [1:0]                     i_operation,
    input  logic [icp_pkg::LD_ADDR_W-1:0]  i_address,
    input  logic [icp_pkg::DATA_W-1:0]     i_data_value,
    output logic [3:0]                     o_status,
    output logic [icp_pkg::DATA_W-1:0]     o_output_value,
    output logic [icp_pkg::DATA_W-1:0]     o_pc_after
);
    import icp_pkg::*;

    localparam int AW  = $clog2(MEM_WORDS);
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int QSW = QCW + 1;
    localparam logic [DATA_W-1:0] MEM_LIM = DATA_W'(MEM_WORDS);

    // Architectural and working registers.
    logic [DATA_W-1:0] r_ip, n_ip;
    logic [DATA_W-1:0] r_rb, n_rb;
    logic [AW-1:0]     r_clr;
    logic [QAW-1:0]    r_qhead;
    logic [QCW-1:0]    r_qcount;
    t_oper             r_oper;
    logic [LD_ADDR_W-1:0] r_laddr;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_word;
    logic [19:0]       r_bcd;
    logic [AW-1:0]     r_ad [3];
    logic [DATA_W-1:0] r_x, r_y;
    logic [DATA_W-1:0] r_prod, r_acc;
    logic [DATA_W-1:0] r_rdata, r_qdata;
    logic [DATA_W-1:0] r_mem [MEM_WORDS];
    logic [DATA_W-1:0] r_q [QUEUE_DEPTH];
    logic [3:0]        r_o_status;
    logic [DATA_W-1:0] r_o_outv, r_o_pc;

    logic [AW-1:0]     m_addr;
    logic              m_we;
    logic [DATA_W-1:0] m_wdata;
    t_opc              opc;
    logic [3:0]        mode;
    logic              mode_wr;
    logic [DATA_W-1:0] slot, a_val, laddr64;
    logic [1:0]        kidx;
    logic [19:0]       bcd_nx;
    logic [19:0]       bcd_t;
    logic [QSW-1:0]    tsum;
    logic [QSW-1:0]    tidx;
    logic [31:0]       mul_a, mul_b;
    logic              q_pop;
    integer            i, j;

    // Opcode and operand mode from the decimal digits.
    assign opc     = f_decode(r_bcd[7:4], r_bcd[3:0]);
    assign mode_wr = (i_cmd.k == f_nops(opc)) && f_writes(opc);
    assign kidx    = i_cmd.k - 2'd1;
    assign slot    = r_ip + DATA_W'(i_cmd.k);
    assign a_val   = ((mode == 4'd2) ? r_rb : '0) + r_rdata;
    assign laddr64 = DATA_W'(r_laddr);
    assign q_pop   = i_cmd.exec && (opc == OPC_IN);

    always_comb begin
        case (i_cmd.k)
            2'd1:    mode = r_bcd[11:8];
            2'd2:    mode = r_bcd[15:12];
            default: mode = r_bcd[19:16];
        endcase
    end

    // Status towards the controller.
    always_comb begin
        o_stat.clr_done = (r_clr == AW'(MEM_WORDS - 1));
        o_stat.oper     = r_oper;
        o_stat.ld_oob   = (laddr64 >= MEM_LIM);
        o_stat.q_full   = (r_qcount >= QCW'(QUEUE_DEPTH));
        o_stat.q_empty  = (r_qcount == '0);
        o_stat.ip_oob   = (r_ip >= MEM_LIM);
        o_stat.rd_neg   = r_rdata[DATA_W-1];
        o_stat.opc      = opc;
        o_stat.mode_bad = (mode > 4'd2) || (mode_wr && mode == 4'd1);
        o_stat.mode_imm = (mode == 4'd1);
        o_stat.slot_oob = (slot >= MEM_LIM);
        o_stat.a_oob    = (a_val >= MEM_LIM);
    end

    // Four double-dabble steps: the low five decimal digits, four bits a cycle.
    always_comb begin
        bcd_t = r_bcd;
        for (i = 0; i < 4; i++) begin
            for (j = 0; j < 5; j++) begin
                if (bcd_t[j*4 +: 4] >= 4'd5) begin
                    bcd_t[j*4 +: 4] = bcd_t[j*4 +: 4] + 4'd3;
                end
            end
            bcd_t = {bcd_t[18:0], r_word[DATA_W-1-i]};
        end
        bcd_nx = bcd_t;
    end

    // Memory port address.
    always_comb begin
        case (i_cmd.maddr)
            MA_CLR:  m_addr = r_clr;
            MA_LOAD: m_addr = laddr64[AW-1:0];
            MA_IP:   m_addr = r_ip[AW-1:0];
            MA_SLOT: m_addr = slot[AW-1:0];
            MA_AD0:  m_addr = r_ad[0];
            MA_AD1:  m_addr = r_ad[1];
            MA_DEST: m_addr = (opc == OPC_IN) ? r_ad[0] : r_ad[2];
            default: m_addr = r_clr;
        endcase
    end

    // Memory write data and the instruction's effect on pointers.
    always_comb begin
        m_we    = i_cmd.clr || i_cmd.load_wr || (i_cmd.exec && f_writes(opc));
        m_wdata = '0;
        n_ip    = r_ip;
        n_rb    = r_rb;
        if (i_cmd.load_wr) begin
            m_wdata = r_val;
        end
        if (i_cmd.exec) begin
            case (opc)
                OPC_ADD: begin
                    m_wdata = r_x + r_y;
                    n_ip    = r_ip + 64'd4;
                end
                OPC_MUL: begin
                    m_wdata = r_acc;
                    n_ip    = r_ip + 64'd4;
                end
                OPC_LT: begin
                    m_wdata = ($signed(r_x) < $signed(r_y)) ? 64'd1 : 64'd0;
                    n_ip    = r_ip + 64'd4;
                end
                OPC_EQ: begin
                    m_wdata = (r_x == r_y) ? 64'd1 : 64'd0;
                    n_ip    = r_ip + 64'd4;
                end
                OPC_IN: begin
                    m_wdata = r_qdata;
                    n_ip    = r_ip + 64'd2;
                end
                OPC_OUT: begin
                    n_ip = r_ip + 64'd2;
                end
                OPC_JT: begin
                    n_ip = (r_x != '0) ? r_y : r_ip + 64'd3;
                end
                OPC_JF: begin
                    n_ip = (r_x == '0) ? r_y : r_ip + 64'd3;
                end
                OPC_RB: begin
                    n_rb = r_rb + r_x;
                    n_ip = r_ip + 64'd2;
                end
                default: begin
                    n_ip = r_ip;
                end
            endcase
        end
    end

    // Data memory: one port, registered read.
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_addr] <= m_wdata;
        end
        r_rdata <= r_mem[m_addr];
    end

    // Input queue: written at the tail, head read registered.
    always_comb begin
        tsum = QSW'(r_qhead) + QSW'(r_qcount);
        tidx = (tsum >= QSW'(QUEUE_DEPTH)) ? tsum - QSW'(QUEUE_DEPTH) : tsum;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_q[tidx[QAW-1:0]] <= r_val;
        end
        r_qdata <= r_q[r_qhead];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip     <= '0;
            r_rb     <= '0;
            r_clr    <= '0;
            r_qhead  <= '0;
            r_qcount <= '0;
        end else begin
            r_ip <= n_ip;
            r_rb <= n_rb;
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.push) begin
                r_qcount <= r_qcount + QCW'(1);
            end else if (q_pop) begin
                r_qcount <= r_qcount - QCW'(1);
                r_qhead  <= (r_qhead == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_qhead + QAW'(1);
            end
        end
    end

    // Multiplier operand selection: one 32 by 32 partial product a cycle.
    always_comb begin
        case (i_cmd.step)
            2'd1:    begin mul_a = r_x[31:0];  mul_b = r_y[63:32]; end
            2'd2:    begin mul_a = r_x[63:32]; mul_b = r_y[31:0];  end
            default: begin mul_a = r_x[31:0];  mul_b = r_y[31:0];  end
        endcase
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_oper  <= t_oper'(i_operation);
            r_laddr <= i_address;
            r_val   <= i_data_value;
        end
        if (i_cmd.word_load) begin
            r_word <= r_rdata;
            r_bcd  <= '0;
        end else if (i_cmd.bcd_step) begin
            r_word <= {r_word[DATA_W-5:0], 4'd0};
            r_bcd  <= bcd_nx;
        end
        if (i_cmd.op_store_imm) begin
            r_ad[kidx] <= slot[AW-1:0];
        end else if (i_cmd.op_store_mem) begin
            r_ad[kidx] <= a_val[AW-1:0];
        end
        if (i_cmd.cap_x) begin
            r_x <= r_rdata;
        end
        if (i_cmd.cap_y) begin
            r_y <= r_rdata;
        end
        if (i_cmd.mul_step) begin
            r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
            if (i_cmd.step == 2'd1) begin
                r_acc <= r_prod;
            end else if (i_cmd.step != 2'd0) begin
                r_acc <= r_acc + {r_prod[31:0], 32'd0};
            end
        end
        if (i_cmd.res_load) begin
            r_o_status <= i_cmd.res_status;
            r_o_outv   <= (i_cmd.res_status == ST_OUTPUT) ? r_x : '0;
            r_o_pc     <= r_ip;
        end
    end

    assign o_status       = r_o_status;
    assign o_output_value = r_o_outv;
    assign o_pc_after     = r_o_pc;

    // Checks on the queue and memory port.
    `AST_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_qcount <= QCW'(QUEUE_DEPTH))
    `AST_IMP(a_pop_nonempty, i_clk, i_rst_n, q_pop, r_qcount != '0 && !i_cmd.push)
    `AST_IMP(a_we_in_range, i_clk, i_rst_n, m_we, DATA_W'(m_addr) < MEM_LIM)

endmodule

// ===== src/icp_ctrl.sv =====
// Controller of the intcode processor: sequences clearing, loads, pushes
// and instruction execution. Depends on icp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module icp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  icp_pkg::t_dp_stat  i_stat,
    output icp_pkg::t_dp_cmd   o_cmd
);
    import icp_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR = 14'h0001,
        S_IDLE  = 14'h0002,
        S_DISP  = 14'h0004,
        S_FETCH = 14'h0008,
        S_DEC   = 14'h0010,
        S_CHK   = 14'h0020,
        S_OPND  = 14'h0040,
        S_OPADR = 14'h0080,
        S_RDX   = 14'h0100,
        S_RDY   = 14'h0200,
        S_CAPY  = 14'h0400,
        S_MUL   = 14'h0800,
        S_EXEC  = 14'h1000,
        S_DONE  = 14'h2000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic [3:0] r_cnt, n_cnt;
    t_status    r_res, n_res;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    t_dp_cmd    cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        n_cnt          = r_cnt;
        n_res          = r_res;
        cmd            = '0;
        cmd.maddr      = MA_CLR;
        cmd.k          = r_k;
        cmd.step       = r_cnt[1:0];
        cmd.res_status = r_res;
        case (r_state)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                n_res   = ST_OK;
                case (i_stat.oper)
                    OPER_LOAD: begin
                        if (i_stat.ld_oob) begin
                            n_res = ST_ADDR_ERR;
                        end else begin
                            cmd.maddr   = MA_LOAD;
                            cmd.load_wr = 1'b1;
                        end
                    end
                    OPER_PUSH: begin
                        if (i_stat.q_full) begin
                            n_res = ST_QUEUE_FULL;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    OPER_EXEC: begin
                        if (i_stat.ip_oob) begin
                            n_res = ST_END;
                        end else begin
                            cmd.maddr = MA_IP;
                            n_state   = S_FETCH;
                        end
                    end
                    default: n_res = ST_OK;
                endcase
            end
            S_FETCH: begin
                if (i_stat.rd_neg) begin
                    n_res   = ST_BAD_OPCODE;
                    n_state = S_DONE;
                end else begin
                    cmd.word_load = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                cmd.bcd_step = 1'b1;
                n_cnt        = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_k = 2'd1;
                if (i_stat.opc == OPC_HALT) begin
                    n_res   = ST_HALT;
                    n_state = S_DONE;
                end else if (i_stat.opc == OPC_BAD) begin
                    n_res   = ST_BAD_OPCODE;
                    n_state = S_DONE;
                end else if (i_stat.opc == OPC_IN && i_stat.q_empty) begin
                    n_res   = ST_NO_INPUT;
                    n_state = S_DONE;
                end else begin
                    n_state = S_OPND;
                end
            end
            // Mode and slot checks, then either immediate or a slot read.
            S_OPND: begin
                if (i_stat.mode_bad) begin
                    n_res   = ST_BAD_MODE;
                    n_state = S_DONE;
                end else if (i_stat.slot_oob) begin
                    n_res   = ST_ADDR_ERR;
                    n_state = S_DONE;
                end else if (i_stat.mode_imm) begin
                    cmd.op_store_imm = 1'b1;
                    if (r_k == f_nops(i_stat.opc)) begin
                        n_state = (i_stat.opc == OPC_IN) ? S_EXEC : S_RDX;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end else begin
                    cmd.maddr = MA_SLOT;
                    n_state   = S_OPADR;
                end
            end
            S_OPADR: begin
                if (i_stat.a_oob) begin
                    n_res   = ST_ADDR_ERR;
                    n_state = S_DONE;
                end else begin
                    cmd.op_store_mem = 1'b1;
                    if (r_k == f_nops(i_stat.opc)) begin
                        n_state = (i_stat.opc == OPC_IN) ? S_EXEC : S_RDX;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_OPND;
                    end
                end
            end
            S_RDX: begin
                cmd.maddr = MA_AD0;
                n_state   = S_RDY;
            end
            S_RDY: begin
                cmd.cap_x = 1'b1;
                cmd.maddr = MA_AD1;
                n_state   = S_CAPY;
            end
            S_CAPY: begin
                cmd.cap_y = 1'b1;
                n_cnt     = '0;
                n_state   = (i_stat.opc == OPC_MUL) ? S_MUL : S_EXEC;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                n_cnt        = r_cnt + 4'd1;
                if (r_cnt == 4'd3) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec  = 1'b1;
                cmd.maddr = MA_DEST;
                n_res     = (i_stat.opc == OPC_OUT) ? ST_OUTPUT : ST_OK;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Output word held until taken.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= 2'd1;
            r_cnt       <= '0;
            r_res       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_cnt       <= n_cnt;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequencing checks.
    `AST_IMP(a_res_slot_free, i_clk, i_rst_n, cmd.res_load, !r_out_valid || i_out_ready)
    `AST_IMP(a_k_nonzero, i_clk, i_rst_n, r_state == S_OPND || r_state == S_OPADR, r_k != 2'd0)
    `AST_NXT(a_accept_disp, i_clk, i_rst_n, accept, r_state == S_DISP)

endmodule

// ===== src/intcode_processor_step.sv =====
// Top level of the intcode processor: controller plus datapath.
// Depends on icp_pkg, icp_ctrl and icp_dp.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_operation, i_address, i_data_value
//  output  | o_out_valid | i_out_ready | o_status, o_output_value, o_pc_after
//
// A load, push or unused word goes through S_DISP and S_DONE, then S_IDLE takes the next.
// An instruction is fetched in S_FETCH, decoded from decimal in S_DEC, resolves
// each operand in S_OPND (and S_OPADR when memory-addressed, on the single memory
// port), reads operands in S_RDX to S_CAPY unless it is an input, uses the shared
// 32x32 multiplier in S_MUL for a multiply, and writes back in S_EXEC.
// A pointer past the end goes from S_DISP to S_DONE, a negative word via S_FETCH.
// After reset the memory is swept to zero, one word a cycle, with o_in_ready low.
// A new word is accepted while the previous result waits; a stalled output holds
// the finished result in its final state.
module intcode_processor_step #(
    parameter int MEM_WORDS   = icp_pkg::MEM_WORDS_DEF,
    parameter int QUEUE_DEPTH = icp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_operation,
    input  logic [icp_pkg::LD_ADDR_W-1:0]  i_address,
    input  logic [icp_pkg::DATA_W-1:0]     i_data_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [3:0]                     o_status,
    output logic [icp_pkg::DATA_W-1:0]     o_output_value,
    output logic [icp_pkg::DATA_W-1:0]     o_pc_after
);
    import icp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    icp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic.
    icp_dp #(
        .MEM_WORDS   (MEM_WORDS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_data_value   (i_data_value),
        .o_status       (o_status),
        .o_output_value (o_output_value),
        .o_pc_after     (o_pc_after)
    );

endmodule

// ===== tb/tb_intcode_processor_step.sv =====
// Self-checking testbench for intcode_processor_step: directed table plus random programs.
// Depends on icp_pkg and the RTL of the block; each result is checked by a predictor or the table.
`timescale 1ns / 100ps

module tb_intcode_processor_step;
    import icp_pkg::*;

    localparam int  MEMW       = 2048;
    localparam int  QDEPTH     = 16;
    localparam int  WDOG_LIMIT = 8000;
    localparam int  LONG_HOLD  = 400;
    localparam int  RAND_ITEMS = 1950;
    localparam logic [63:0] SGN = 64'h8000_0000_0000_0000;

    typedef struct {
        t_status     st;
        logic [63:0] outv;
        logic [63:0] pc;
    } result_t;

    typedef struct {
        t_oper       op;
        logic [10:0] addr;
        logic [63:0] data;
        bit          typed;
        result_t     res;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = '0;
    logic [10:0] i_address = '0;
    logic [63:0] i_data_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_status;
    logic [63:0] o_output_value;
    logic [63:0] o_pc_after;

    // Predictor state: a private copy of the machine.
    logic [63:0] mem_img [MEMW];
    logic [63:0] ip_img;
    logic [63:0] rbase_img;
    logic [63:0] fifo_img [QDEPTH];
    int          fifo_head;
    int          fifo_count;

    result_t     pending_q[$];
    stim_row_t   dir_rows[$];
    int          words_sent = 0;
    int          n_fail = 0;
    int          n_checked = 0;
    int          status_seen [9];
    int          idle_cycles = 0;
    bit          hold_request = 1'b0;
    bit          no_idle = 1'b0;

    intcode_processor_step i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_data_value   (i_data_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_output_value (o_output_value),
        .o_pc_after     (o_pc_after)
    );

    always #6 i_clk = ~i_clk;

    // Resolve one operand to a memory address; modes are checked before the slot.
    function automatic t_status operand_address(input logic [63:0] w, input int k,
                                                input bit wr, output logic [63:0] a);
        logic [63:0] m;
        logic [63:0] slot;
        int          i;
        m = w / 100;
        for (i = 1; i < k; i++) m = m / 10;
        m = m % 10;
        a = '0;
        if (m > 2 || (wr && m == 1)) return ST_BAD_MODE;
        slot = ip_img + k;
        if (slot >= MEMW) return ST_ADDR_ERR;
        if (m == 1) a = slot;
        else if (m == 0) a = mem_img[slot[10:0]];
        else a = rbase_img + mem_img[slot[10:0]];
        if (a >= MEMW) return ST_ADDR_ERR;
        return ST_OK;
    endfunction

    // Run one instruction at the predicted pointer.
    task automatic exec_instruction(output t_status st, output logic [63:0] outv);
        logic [63:0] w, opc, x, y;
        logic [63:0] ad [3];
        int          n, k;
        bit          wr;
        outv = '0;
        ad = '{default: '0};
        st = ST_OK;
        if (ip_img >= MEMW) begin
            st = ST_END;
            return;
        end
        w = mem_img[ip_img[10:0]];
        if (w[63]) begin
            st = ST_BAD_OPCODE;
            return;
        end
        opc = w % 100;
        case (opc)
            1, 2, 7, 8: begin n = 3; wr = 1'b1; end
            3:          begin n = 1; wr = 1'b1; end
            4, 9:       begin n = 1; wr = 1'b0; end
            5, 6:       begin n = 2; wr = 1'b0; end
            99:         begin st = ST_HALT; return; end
            default:    begin st = ST_BAD_OPCODE; return; end
        endcase
        if (opc == 3 && fifo_count == 0) begin
            st = ST_NO_INPUT;
            return;
        end
        for (k = 1; k <= n; k++) begin
            st = operand_address(w, k, wr && k == n, ad[k-1]);
            if (st != ST_OK) return;
        end
        x = mem_img[ad[0][10:0]];
        y = mem_img[ad[1][10:0]];
        case (opc)
            1: begin mem_img[ad[2][10:0]] = x + y; ip_img += 4; end
            2: begin mem_img[ad[2][10:0]] = x * y; ip_img += 4; end
            7: begin mem_img[ad[2][10:0]] = ($signed(x) < $signed(y)) ? 1 : 0; ip_img += 4; end
            8: begin mem_img[ad[2][10:0]] = (x == y) ? 1 : 0; ip_img += 4; end
            3: begin
                mem_img[ad[0][10:0]] = fifo_img[fifo_head];
                fifo_head = (fifo_head + 1) % QDEPTH;
                fifo_count--;
                ip_img += 2;
            end
            4: begin outv = x; ip_img += 2; st = ST_OUTPUT; end
            5: ip_img = (x != 0) ? y : ip_img + 3;
            6: ip_img = (x == 0) ? y : ip_img + 3;
            default: begin rbase_img += x; ip_img += 2; end
        endcase
    endtask

    // Predict the result of one input word and update the predictor state.
    task automatic predict_word(input t_oper op, input logic [10:0] addr,
                                input logic [63:0] data, output result_t r);
        r.st = ST_OK;
        r.outv = '0;
        case (op)
            OPER_LOAD: mem_img[addr] = data;
            OPER_PUSH: begin
                if (fifo_count >= QDEPTH) begin
                    r.st = ST_QUEUE_FULL;
                end else begin
                    fifo_img[(fifo_head + fifo_count) % QDEPTH] = data;
                    fifo_count++;
                end
            end
            OPER_EXEC: exec_instruction(r.st, r.outv);
            default: ;
        endcase
        r.pc = ip_img;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rnd_word();
        case ($urandom_range(0, 6))
            0: return 64'd0;
            1: return 64'($signed($urandom_range(0, 20)) - 10);
            2: return 64'h7FFF_FFFF_FFFF_FFFF;
            3: return SGN;
            4: return 64'($urandom_range(0, 100));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word to the block; the expectation is queued before it is offered.
    task automatic send_word(input t_oper op, input logic [10:0] addr, input logic [63:0] data,
                             input bit typed = 1'b0, input result_t tres = '{ST_OK, 0, 0});
        result_t r;
        int      g;
        predict_word(op, addr, data, r);
        pending_q.push_back(typed ? tres : r);
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_address    <= addr;
        i_data_value <= data;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input t_oper op, input logic [10:0] addr, input logic [63:0] data,
                           input bit typed = 1'b0, input t_status st = ST_OK,
                           input logic [63:0] outv = 0, input logic [63:0] pc = 0);
        stim_row_t row;
        row.op = op;
        row.addr = addr;
        row.data = data;
        row.typed = typed;
        row.res = '{st, outv, pc};
        dir_rows.push_back(row);
    endtask

    // Build one well-formed instruction at the pointer (mostly), load it and execute it.
    task automatic run_instruction();
        logic [63:0] opc, word, v, a;
        logic [63:0] par [3];
        int          md [3];
        int          n, k, kind;
        bit          wr, writes, oob;
        logic [63:0] opc_list [10] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 99};
        kind = $urandom_range(0, 99);
        par = '{default: '0};
        md = '{$urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 2)};
        opc = (ip_img > 900) ? 5 : opc_list[$urandom_range(0, 9)];
        case (opc)
            1, 2, 7, 8: begin n = 3; wr = 1'b1; end
            3:          begin n = 1; wr = 1'b1; end
            4, 9:       begin n = 1; wr = 1'b0; end
            5, 6:       begin n = 2; wr = 1'b0; end
            default:    begin n = 0; wr = 1'b0; end
        endcase
        if (opc == 3 && $urandom_range(0, 3) != 0)
            repeat ($urandom_range(1, 2)) send_word(OPER_PUSH, 11'($urandom), rnd_word());
        for (k = 0; k < n; k++) begin
            writes = wr && k == n - 1;
            md[k] = writes ? ($urandom_range(0, 1) ? 2 : 0) : $urandom_range(0, 2);
            oob = 1'b0;
            if (ip_img <= 900 && $urandom_range(0, 49) == 0)
                md[k] = (writes && $urandom_range(0, 1)) ? 1 : $urandom_range(3, 9);
            if ((opc == 5 || opc == 6) && k == 1) v = $urandom_range(0, 900);
            else if ((opc == 5 || opc == 6) && $urandom_range(0, 1)) v = 0;
            else v = rnd_word();
            if (ip_img > 900) begin
                md[k] = 1;
                if (k == 0) v = 1;
            end
            a = 1024 + 16 * k + $urandom_range(0, 15);
            if (ip_img <= 900 && $urandom_range(0, 39) == 0) begin
                oob = 1'b1;
                a = $urandom_range(0, 1) ? 64'(2048 + $urandom_range(0, 1000)) : ~64'($urandom);
            end
            case (md[k])
                1: par[k] = v;
                0: par[k] = a;
                2: par[k] = a - rbase_img;
                default: par[k] = rnd_word();
            endcase
            if (!writes && !oob && (md[k] == 0 || md[k] == 2))
                send_word(OPER_LOAD, a[10:0], v);
        end
        word = opc + 100 * md[0] + 1000 * md[1] + 10000 * md[2];
        if (ip_img <= 900 && kind < 4)
            word = $urandom_range(0, 1) ? {1'b1, 31'($urandom), $urandom}
                                        : 64'(100 * $urandom_range(0, 999) + $urandom_range(10, 98));
        send_word(OPER_LOAD, ip_img[10:0], word);
        for (k = 0; k < n; k++) send_word(OPER_LOAD, 11'(ip_img + 1 + k), par[k]);
        send_word(OPER_EXEC, 11'($urandom), rnd_word());
    endtask

    // Result side: random back-pressure, one long hold-off, and the comparison.
    always @(posedge i_clk) begin
        result_t e;
        int      hold;
        if (o_out_valid && i_out_ready && i_rst_n) begin
            if (pending_q.size() == 0) begin
                $display("%0t unexpected word: status %0d value %h pc %h",
                         $time, o_status, o_output_value, o_pc_after);
                n_fail++;
            end else begin
                e = pending_q.pop_front();
                n_checked++;
                if (o_status < 9) status_seen[o_status]++;
                if (o_status !== e.st || o_output_value !== e.outv || o_pc_after !== e.pc) begin
                    $display("%0t mismatch: expected status %0d value %h pc %h, got %0d %h %h",
                             $time, e.st, e.outv, e.pc, o_status, o_output_value, o_pc_after);
                    n_fail++;
                end
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            i_out_ready <= 1'b0;
            for (hold = 0; hold < LONG_HOLD; hold++) @(posedge i_clk);
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) < 70) ||
                           ($urandom_range(0, 99) < 40 && o_out_valid);
        end
    end

    // Watchdog: cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t watchdog expired, %0d words outstanding", $time, pending_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        bit hold_done, pause_done;
        foreach (mem_img[i]) mem_img[i] = '0;
        foreach (fifo_img[i]) fifo_img[i] = '0;
        ip_img = '0;
        rbase_img = '0;
        fifo_head = 0;
        fifo_count = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset state, each status code but end and queue full, and the memory edges.
        add_row(OPER_EXEC, 0, 0, 1, ST_BAD_OPCODE, 0, 0);
        add_row(OPER_NONE, 2047, '1, 1, ST_OK, 0, 0);
        add_row(OPER_LOAD, 0, 3, 1, ST_OK, 0, 0);
        add_row(OPER_EXEC, 0, 0, 1, ST_NO_INPUT, 0, 0);
        add_row(OPER_PUSH, 0, 64'h7FFF_FFFF_FFFF_FFFF, 1, ST_OK, 0, 0);
        add_row(OPER_PUSH, 2047, SGN, 1, ST_OK, 0, 0);
        add_row(OPER_LOAD, 1, 100, 1, ST_OK, 0, 0);
        add_row(OPER_EXEC, 0, 0, 1, ST_OK, 0, 2);
        add_row(OPER_LOAD, 2, 104);
        add_row(OPER_LOAD, 3, '1);
        add_row(OPER_EXEC, 0, 0, 1, ST_OUTPUT, '1, 4);
        add_row(OPER_LOAD, 4, 99);
        add_row(OPER_EXEC, 0, 0, 1, ST_HALT, 0, 4);
        add_row(OPER_LOAD, 4, -64'sd5);
        add_row(OPER_EXEC, 0, 0, 1, ST_BAD_OPCODE, 0, 4);
        add_row(OPER_LOAD, 4, 30001);
        add_row(OPER_EXEC, 0, 0, 1, ST_BAD_MODE, 0, 4);
        add_row(OPER_LOAD, 4, 11101);
        add_row(OPER_EXEC, 0, 0, 1, ST_BAD_MODE, 0, 4);
        add_row(OPER_LOAD, 4, 1002);
        add_row(OPER_LOAD, 5, 2048);
        add_row(OPER_EXEC, 0, 0, 1, ST_ADDR_ERR, 0, 4);
        add_row(OPER_LOAD, 5, 100);
        add_row(OPER_LOAD, 6, '1);
        add_row(OPER_LOAD, 7, 101);
        add_row(OPER_EXEC, 0, 0);
        add_row(OPER_LOAD, 8, 1105);
        add_row(OPER_LOAD, 9, 1);
        add_row(OPER_LOAD, 10, 2045);
        add_row(OPER_EXEC, 0, 0);
        add_row(OPER_LOAD, 2045, 1101);
        add_row(OPER_EXEC, 0, 0, 1, ST_ADDR_ERR, 0, 2045);
        add_row(OPER_LOAD, 2045, 1106);
        add_row(OPER_LOAD, 2047, 20);
        add_row(OPER_EXEC, 0, 0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data,
                      dir_rows[i].typed, dir_rows[i].res);

        // Random programs, with occasional push bursts and ignored words.
        while (words_sent < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
            if ($urandom_range(0, 59) == 0)
                repeat ($urandom_range(10, 20)) send_word(OPER_PUSH, 11'($urandom), rnd_word());
            if ($urandom_range(0, 49) == 0)
                send_word(OPER_NONE, 11'($urandom), rnd_word());
            if (!hold_done && words_sent > 600) begin
                hold_done = 1'b1;
                no_idle = 1'b0;
                hold_request = 1'b1;
            end
            if (!pause_done && words_sent > 1200) begin
                pause_done = 1'b1;
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                wait_drained();
            end
            run_instruction();
        end

        // Finally jump out of memory and execute past the end.
        send_word(OPER_LOAD, ip_img[10:0], 1105);
        send_word(OPER_LOAD, 11'(ip_img + 1), 1);
        send_word(OPER_LOAD, 11'(ip_img + 2), 2048 + $urandom_range(0, 5000));
        send_word(OPER_EXEC, 0, 0);
        send_word(OPER_EXEC, 0, 0);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (60) @(posedge i_clk);

        $display("Checked %0d words: ok %0d, output %0d, no input %0d, halt %0d, end %0d,",
                 n_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        $display("  bad opcode %0d, bad mode %0d, queue full %0d, address error %0d.",
                 status_seen[5], status_seen[6], status_seen[7], status_seen[8]);
        if (n_fail == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
